>>> hw/rtl/fwkr_pkg.sv
// ----------------------------------------------------------------------------
// fwkr_pkg
// Shared types and constants for the FIFO with keyed removal.
// ----------------------------------------------------------------------------
`default_nettype none

package fwkr_pkg;

    // Field widths of one command and one response.
    localparam int ID_W      = 32;
    localparam int OP_W      = 2;
    localparam int ERR_W     = 2;
    localparam int CNT_OUT_W = 7;

    // Default queue depth.
    localparam int QUEUE_DEPTH_DEF = 64;

    // Command opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    // Response error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_EMPTY     = 2'd1,
        ERR_NOT_FOUND = 2'd2,
        ERR_FULL      = 2'd3
    } t_err;

    // One response as it leaves the sequencer.
    typedef struct packed {
        logic [ERR_W-1:0]     error_code;
        logic [ID_W-1:0]      popped_id;
        logic                 found;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/fwkr_if.sv
// ----------------------------------------------------------------------------
// fwkr_if
// Valid/ready channel interfaces for commands and responses.
// ----------------------------------------------------------------------------
`default_nettype none

// Command channel: opcode and identifier.
interface fwkr_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [fwkr_pkg::OP_W-1:0]  opcode;
    logic [fwkr_pkg::ID_W-1:0]  voter_id;

    modport source (output valid, output opcode, output voter_id, input ready);
    modport sink   (input valid, input opcode, input voter_id, output ready);
endinterface

// Response channel: error code, popped identifier, match flag and count.
interface fwkr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fwkr_pkg::ERR_W-1:0]     error_code;
    logic [fwkr_pkg::ID_W-1:0]      popped_id;
    logic                           found;
    logic [fwkr_pkg::CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output error_code, output popped_id,
                    output found, output entry_count, input ready);
    modport sink   (input valid, input error_code, input popped_id,
                    input found, input entry_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fifo_with_keyed_removal_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_keyed_removal_unit
// Ordered queue of identifiers with push, pop, removal by key and search.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                                    Transfer
//  i_cmd    in         opcode, voter_id                           valid & ready
//  o_rsp    out        error_code, popped_id, found, entry_count  valid & ready
//
//  One command is handled at a time. Push, and commands refused because the
//  queue is empty or full, need no read; pop reads the head entry. Search
//  and remove walk the entries from the head through the single read port of
//  the entry memory, one entry a cycle, to the last entry on a miss; a removal
//  moves the later entries in the same walk. Reset clears state, head, count
//  and the output valid flag; the memory needs no clearing pass.
//  A response waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_keyed_removal_unit #(
    parameter int QUEUE_DEPTH = fwkr_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    fwkr_cmd_if.sink   i_cmd,
    fwkr_rsp_if.source o_rsp
);
    import fwkr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic            res_valid;
    logic            res_ready;
    t_result         res;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [ID_W-1:0] wdata;
    logic            re;
    logic [AW-1:0]   raddr;
    logic [ID_W-1:0] rdata;

    logic            r_out_valid;
    t_result         r_out;

    fwkr_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .i_opcode    (i_cmd.opcode),
        .i_voter_id  (i_cmd.voter_id),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    fwkr_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register: loads when empty or when its response is transferred.
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.error_code  = r_out.error_code;
    assign o_rsp.popped_id   = r_out.popped_id;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.entry_count = r_out.entry_count;

endmodule

`default_nettype wire

>>> hw/rtl/fwkr_store.sv
// ----------------------------------------------------------------------------
// fwkr_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwkr_store #(
    parameter int DEPTH = fwkr_pkg::QUEUE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [fwkr_pkg::ID_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [fwkr_pkg::ID_W-1:0] o_rdata
);
    import fwkr_pkg::*;

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/fwkr_ctrl.sv
// ----------------------------------------------------------------------------
// fwkr_ctrl
// Sequencer: keeps head and count, walks the memory for search and removal,
// and closes the gap left by a removed entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fwkr_ctrl #(
    parameter int DEPTH = fwkr_pkg::QUEUE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Command side.
    input  wire logic                      i_cmd_valid,
    output logic                           o_cmd_ready,
    input  wire logic [fwkr_pkg::OP_W-1:0] i_opcode,
    input  wire logic [fwkr_pkg::ID_W-1:0] i_voter_id,
    // Response side.
    output logic                           o_res_valid,
    input  wire logic                      i_res_ready,
    output fwkr_pkg::t_result              o_res,
    // Memory port.
    output logic                           o_we,
    output logic      [AW-1:0]             o_waddr,
    output logic      [fwkr_pkg::ID_W-1:0] o_wdata,
    output logic                           o_re,
    output logic      [AW-1:0]             o_raddr,
    input  wire logic [fwkr_pkg::ID_W-1:0] i_rdata
);
    import fwkr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POPW  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [ID_W-1:0] r_key, n_key;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_pos, n_pos;
    t_result         r_res, n_res;

    logic [CW-1:0]   pos_nx;
    logic            last;
    logic            full;
    logic            empty;
    logic [CW+6:0]   cnt_ext;

    // Physical address of a queue position: head plus offset, wrapped once.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign pos_nx  = r_pos + CW'(1);
    assign last    = (pos_nx == r_count);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign cnt_ext = (CW+7)'(r_count);

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);

    // The count is taken from the settled state once the operation is over.
    always_comb begin
        o_res             = r_res;
        o_res.entry_count = cnt_ext[CNT_OUT_W-1:0];
    end

    // Next-state and memory access logic.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_head  = r_head;
        n_count = r_count;
        n_pos   = r_pos;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = phys(r_head, r_count);
        o_wdata = r_key;
        o_re    = 1'b0;
        o_raddr = phys(r_head, pos_nx);

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_op  = t_op'(i_opcode);
                    n_key = i_voter_id;
                    n_res = '0;
                    n_pos = '0;
                    unique case (t_op'(i_opcode))
                        OP_PUSH: begin
                            if (full) begin
                                n_res.error_code = ERR_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_wdata = i_voter_id;
                                n_count = r_count + CW'(1);
                            end
                            n_state = ST_DONE;
                        end
                        OP_POP: begin
                            if (empty) begin
                                n_res.error_code = ERR_EMPTY;
                                n_state          = ST_DONE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = r_head;
                                n_state = ST_POPW;
                            end
                        end
                        default: begin
                            if (empty) begin
                                n_res.error_code = ERR_EMPTY;
                                n_state          = ST_DONE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = r_head;
                                n_state = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            // Head entry arrives from memory.
            ST_POPW: begin
                n_res.popped_id = i_rdata;
                n_head          = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                n_count         = r_count - CW'(1);
                n_state         = ST_DONE;
            end

            // Compare the entry at r_pos and fetch the next one.
            ST_SCAN: begin
                if (i_rdata == r_key) begin
                    n_res.found = 1'b1;
                    if (r_op == OP_SEARCH) begin
                        n_state = ST_DONE;
                    end else if (last) begin
                        n_count = r_count - CW'(1);
                        n_state = ST_DONE;
                    end else begin
                        o_re    = 1'b1;
                        n_pos   = pos_nx;
                        n_state = ST_SHIFT;
                    end
                end else if (last) begin
                    n_res.error_code = ERR_NOT_FOUND;
                    n_state          = ST_DONE;
                end else begin
                    o_re  = 1'b1;
                    n_pos = pos_nx;
                end
            end

            // Move the entry at r_pos one place towards the head.
            ST_SHIFT: begin
                o_we    = 1'b1;
                o_waddr = phys(r_head, r_pos - CW'(1));
                o_wdata = i_rdata;
                if (last) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end else begin
                    o_re  = 1'b1;
                    n_pos = pos_nx;
                end
            end

            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_pos <= n_pos;
        r_res <= n_res;
    end

endmodule

`default_nettype wire
